[hdl/wcvt_pkg.sv]
// ----------------------------------------------------------------------------
// wcvt_pkg
// Shared types and constants for the weighted class vote tracker.
// ----------------------------------------------------------------------------
package wcvt_pkg;

  localparam int ID_W    = 8;
  localparam int SCORE_W = 16;
  localparam int CLASS_W = 6;
  localparam int PROB_W  = 16;
  localparam int SUM_W   = 32;

  localparam int CLASS_COUNT_DEF = 64;
  localparam int FRAC_BITS_DEF   = 16;

  // Status codes carried with every result.
  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_BAD_ID = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]    seg_class;
    logic [SCORE_W-1:0] class_conf;
    logic [SCORE_W-1:0] inst_conf;
  } obs_t;

  typedef struct packed {
    logic [CLASS_W-1:0] best_class;
    logic [PROB_W-1:0]  best_prob;
    logic               best_valid;
    logic               status;
  } vote_t;

  // One row of the per-class table.
  typedef struct packed {
    logic             seen;
    logic [SUM_W-1:0] weighted_sum;
    logic [SUM_W-1:0] weight_sum;
  } entry_t;

endpackage

[hdl/wcvt_ram.sv]
// ----------------------------------------------------------------------------
// wcvt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module wcvt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/wcvt_div.sv]
// ----------------------------------------------------------------------------
// wcvt_div
// Restoring divider giving floor((num << FRAC_BITS) / den), saturated to
// the probability width. One quotient bit per cycle.
// ----------------------------------------------------------------------------
module wcvt_div
  import wcvt_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SUM_W-1:0]  num,
  input  logic [SUM_W-1:0]  den,
  output logic              done,
  output logic [PROB_W-1:0] quotient
);

  localparam int NW    = SUM_W + FRAC_BITS;
  localparam int DW    = SUM_W + PROB_W;
  localparam int CW    = (NW > DW) ? NW : DW;
  localparam int STEPS = PROB_W + 1;
  localparam int CNT_W = $clog2(STEPS);

  logic [CW-1:0]    rem;
  logic [CW-1:0]    dsh;
  logic [PROB_W:0]  q;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             ge;
  logic [CW-1:0]    diff;

  assign ge   = (rem >= dsh);
  assign diff = rem - dsh;

  // The first step tests the divisor at weight 2^PROB_W; a set bit there
  // means the mean does not fit and the result saturates.
  assign quotient = q[PROB_W] ? {PROB_W{1'b1}} : q[PROB_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= CW'({num, {FRAC_BITS{1'b0}}});
      dsh <= CW'({den, {PROB_W{1'b0}}});
      q   <= '0;
      cnt <= '0;
    end else if (busy) begin
      rem <= ge ? diff : rem;
      dsh <= dsh >> 1;
      q   <= {q[PROB_W-1:0], ge};
      cnt <= cnt + CNT_W'(1);
    end
  end

endmodule

[hdl/weighted_class_vote_tracker_top.sv]
// ----------------------------------------------------------------------------
// weighted_class_vote_tracker_top
// Flow: a request with a valid class id that needs a mean passes through MUL,
//   UPD, DIV and EMIT; a first sighting or a zero weight sum skips DIV, and an
//   out-of-range id goes from MUL straight to EMIT.
// Throughput: one request at a time, the longest waiting on the 17-step
//   bit-serial divider; EMIT also waits while the output register is full.
// Reset: synchronous; afterwards a clearing pass writes zero to every row of
//   the class table, and no request is accepted until it ends.
// ----------------------------------------------------------------------------
module weighted_class_vote_tracker_top
  import wcvt_pkg::*;
#(
  parameter int CLASS_COUNT = CLASS_COUNT_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  obs_valid,
  output logic  obs_ready,
  input  obs_t  obs,
  output logic  vote_valid,
  input  logic  vote_ready,
  output vote_t vote
);

  localparam int AW = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
  localparam int EW = $bits(entry_t);

  // Controller states. CLEAR sweeps the table after reset, MUL forms the
  // score product while the table row is read, UPD writes the new sums back
  // and, when a mean is needed, launches the divider, DIV waits for the mean,
  // and EMIT hands the result to the output register.
  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_MUL   = 6'b000100,
    S_UPD   = 6'b001000,
    S_DIV   = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  logic [AW-1:0]      clr_idx;
  logic [ID_W-1:0]    id_r;
  logic [SCORE_W-1:0] cs_r;
  logic [SCORE_W-1:0] is_r;
  logic [SUM_W-1:0]   prod_r;
  logic               status_r;
  logic [CLASS_W-1:0] held_class;
  logic [PROB_W-1:0]  held_prob;
  logic               held_valid;

  logic                   accept;
  logic                   id_bad;
  logic [2*SCORE_W-1:0]   mult;
  entry_t                 cur;
  entry_t                 upd;
  logic [SUM_W:0]         ws_add;
  logic [SUM_W:0]         wt_add;
  logic                   do_div;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [EW-1:0] ram_rdata;

  logic              div_start;
  logic              div_done;
  logic [PROB_W-1:0] div_quo;

  // A new request is taken only when the previous one has been fully
  // handled; the output register lets a finished result wait for the sink
  // while the next request is already being worked on.
  assign obs_ready = (state == S_IDLE);
  assign accept    = obs_valid && obs_ready;

  assign id_bad = (32'(id_r) >= 32'(CLASS_COUNT));
  assign mult   = cs_r * is_r;

  // Read-modify-write of the class row. The row read at acceptance is held
  // in the RAM's output register until the write-back in UPD. Only one
  // request is in flight, so the write always lands before the next read.
  assign cur    = entry_t'(ram_rdata);
  assign ws_add = {1'b0, cur.weighted_sum} + {1'b0, prod_r};
  assign wt_add = {1'b0, cur.weight_sum} + {{(SUM_W - SCORE_W + 1){1'b0}}, is_r};

  always_comb begin
    upd.seen = 1'b1;
    if (!cur.seen) begin
      // First sighting of the class only seeds its sums.
      upd.weighted_sum = prod_r;
      upd.weight_sum   = SUM_W'(is_r);
    end else begin
      upd.weighted_sum = ws_add[SUM_W] ? {SUM_W{1'b1}} : ws_add[SUM_W-1:0];
      upd.weight_sum   = wt_add[SUM_W] ? {SUM_W{1'b1}} : wt_add[SUM_W-1:0];
    end
  end

  // A mean is formed only for a class seen before, and never over a zero
  // weight sum.
  assign do_div    = cur.seen && (upd.weight_sum != '0);
  assign div_start = (state == S_UPD) && do_div;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(id_r);
    ram_wdata = upd;
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx;
        ram_wdata = '0;
      end
      S_UPD: begin
        ram_we = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_idx == AW'(CLASS_COUNT - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        state_next = id_bad ? S_EMIT : S_UPD;
      end
      S_UPD: begin
        state_next = do_div ? S_DIV : S_EMIT;
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!vote_valid || vote_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_idx    <= '0;
      held_class <= '0;
      held_prob  <= '0;
      held_valid <= 1'b0;
      vote_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_idx <= clr_idx + AW'(1);
      end
      // The held best changes only on a strictly greater mean.
      if (state == S_DIV && div_done && div_quo > held_prob) begin
        held_class <= CLASS_W'(id_r);
        held_prob  <= div_quo;
        held_valid <= 1'b1;
      end
      if (state == S_EMIT && (!vote_valid || vote_ready)) begin
        vote_valid <= 1'b1;
      end else if (vote_ready) begin
        vote_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      id_r <= obs.seg_class;
      cs_r <= obs.class_conf;
      is_r <= obs.inst_conf;
    end
    if (state == S_MUL) begin
      prod_r   <= SUM_W'(mult >> FRAC_BITS);
      status_r <= id_bad ? STATUS_BAD_ID : STATUS_OK;
    end
    if (state == S_EMIT && (!vote_valid || vote_ready)) begin
      vote.best_class <= held_class;
      vote.best_prob  <= held_prob;
      vote.best_valid <= held_valid;
      vote.status     <= status_r;
    end
  end

  wcvt_ram #(
    .WIDTH (EW),
    .DEPTH (CLASS_COUNT)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (AW'(obs.seg_class)),
    .rdata (ram_rdata)
  );

  wcvt_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .num      (upd.weighted_sum),
    .den      (upd.weight_sum),
    .done     (div_done),
    .quotient (div_quo)
  );

endmodule

[hdl/wcvt_checker.sv]
// ----------------------------------------------------------------------------
// wcvt_checker
// Port-level checks for the weighted class vote tracker, bound to its top.
// ----------------------------------------------------------------------------
module wcvt_checker
  import wcvt_pkg::*;
(
  input logic  clk,
  input logic  rst,
  input logic  obs_valid,
  input logic  obs_ready,
  input obs_t  obs,
  input logic  vote_valid,
  input logic  vote_ready,
  input vote_t vote
);

  logic [PROB_W-1:0] last_prob;
  logic              last_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_prob  <= '0;
      last_valid <= 1'b0;
    end else if (vote_valid && vote_ready) begin
      last_prob  <= vote.best_prob;
      last_valid <= vote.best_valid;
    end
  end

  // A stalled result holds its contents.
  a_vote_hold: assert property (@(posedge clk) disable iff (rst)
    vote_valid && !vote_ready |=> vote_valid && $stable(vote))
    else $error("result changed while stalled");

  // The best mean never falls and the best mark never clears.
  a_best_monotonic: assert property (@(posedge clk) disable iff (rst)
    vote_valid |-> (vote.best_prob >= last_prob) && (vote.best_valid || !last_valid))
    else $error("best mean went backwards");

  // Without a best class the held values are still their reset values.
  a_no_best_zero: assert property (@(posedge clk) disable iff (rst)
    vote_valid && !vote.best_valid |-> vote.best_prob == '0 && vote.best_class == '0)
    else $error("best values set without a best class");

  // Requests are handled one at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    obs_valid && obs_ready |=> !obs_ready)
    else $error("second request taken while busy");

endmodule

bind weighted_class_vote_tracker_top wcvt_checker u_chk (.*);

[verif/weighted_class_vote_tracker_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// weighted_class_vote_tracker_top_tb
// Self-checking bench for the weighted class vote tracker. Observation
// requests go in through a queue-fed driver, and a monitor checks every vote
// against a local model of the per-class sums and the held best class.
// ----------------------------------------------------------------------------
module weighted_class_vote_tracker_top_tb;
  import wcvt_pkg::*;

  localparam logic [SUM_W-1:0]  SUM_SAT    = '1;
  localparam logic [PROB_W-1:0] PROB_SAT   = '1;
  localparam int                HOLD_AT    = 380;  // result count that starts the long stall
  localparam int                HOLD_LEN   = 300;
  localparam int                DRAIN_WAIT = 30;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  obs_valid = 1'b0;
  logic  obs_ready;
  obs_t  obs = '0;
  logic  vote_valid;
  logic  vote_ready = 1'b0;
  vote_t vote;

  // Observations waiting for the driver, and votes waiting for the monitor.
  obs_t  pending_obs[$];
  vote_t expected_votes[$];

  // Local copy of the class table and the held best class.
  logic [SUM_W-1:0]  score_acc [CLASS_COUNT_DEF];
  logic [SUM_W-1:0]  weight_acc[CLASS_COUNT_DEF];
  logic              class_seen[CLASS_COUNT_DEF];
  logic [CLASS_W-1:0] lead_class = '0;
  logic [PROB_W-1:0]  lead_prob  = '0;
  logic               lead_valid = 1'b0;

  int send_idle_pct  = 16;
  int recv_stall_pct = 49;
  int queued_cnt = 0;
  int taken_cnt  = 0;
  int got_cnt    = 0;
  int err_cnt    = 0;
  int hold_left  = 0;
  bit hold_done  = 1'b0;

  // Coverage tallies kept by the model, reported in the summary.
  int n_bad_id = 0;
  int n_first  = 0;
  int n_zero_w = 0;
  int n_lead   = 0;

  weighted_class_vote_tracker_top dut (
    .clk       (clk),
    .rst       (rst),
    .obs_valid (obs_valid),
    .obs_ready (obs_ready),
    .obs       (obs),
    .vote_valid(vote_valid),
    .vote_ready(vote_ready),
    .vote      (vote)
  );

  always #1 clk = ~clk;

  initial begin
    for (int i = 0; i < CLASS_COUNT_DEF; i++) begin
      score_acc[i]  = '0;
      weight_acc[i] = '0;
      class_seen[i] = 1'b0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
  end

  // Works out the vote for one accepted observation and updates the local
  // class table the same way the block must.
  function automatic vote_t vote_for(obs_t o);
    logic [31:0]        full_prod;
    logic [SUM_W-1:0]   prod;
    logic [SUM_W:0]     score_sum;
    logic [SUM_W:0]     weight_sum;
    logic [47:0]        mean;
    logic [CLASS_W-1:0] idx;
    vote_t              v;
    if (o.seg_class >= CLASS_COUNT_DEF) begin
      // Out-of-range ids leave everything alone and only flag the request.
      n_bad_id++;
      v = '{best_class: lead_class, best_prob: lead_prob, best_valid: lead_valid,
            status: STATUS_BAD_ID};
      return v;
    end
    idx       = o.seg_class[CLASS_W-1:0];
    full_prod = 32'(o.class_conf) * 32'(o.inst_conf);
    prod      = SUM_W'(full_prod >> FRAC_BITS_DEF);
    if (!class_seen[idx]) begin
      // First sighting of a class just loads its sums; no vote is taken.
      n_first++;
      score_acc[idx]  = prod;
      weight_acc[idx] = SUM_W'(o.inst_conf);
      class_seen[idx] = 1'b1;
    end else begin
      score_sum  = {1'b0, score_acc[idx]} + {1'b0, prod};
      weight_sum = {1'b0, weight_acc[idx]} + (SUM_W + 1)'(o.inst_conf);
      score_acc[idx]  = score_sum[SUM_W]  ? SUM_SAT : score_sum[SUM_W-1:0];
      weight_acc[idx] = weight_sum[SUM_W] ? SUM_SAT : weight_sum[SUM_W-1:0];
      if (weight_acc[idx] == '0) begin
        n_zero_w++;
      end else begin
        mean = (48'(score_acc[idx]) << FRAC_BITS_DEF) / 48'(weight_acc[idx]);
        if (mean > 48'(PROB_SAT)) begin
          mean = 48'(PROB_SAT);
        end
        // Strictly greater only: a tie keeps the class that got there first.
        if (mean[PROB_W-1:0] > lead_prob) begin
          n_lead++;
          lead_class = idx;
          lead_prob  = mean[PROB_W-1:0];
          lead_valid = 1'b1;
        end
      end
    end
    v = '{best_class: lead_class, best_prob: lead_prob, best_valid: lead_valid,
          status: STATUS_OK};
    return v;
  endfunction

  task automatic add_obs(input int id, input int cs, input int inst);
    obs_t o;
    o.seg_class  = ID_W'(id);
    o.class_conf = SCORE_W'(cs);
    o.inst_conf  = SCORE_W'(inst);
    pending_obs.push_back(o);
    queued_cnt++;
  endtask

  // Random observations. Most ids land in range and many repeat from a small
  // set of classes, so sums build up and the running means get compared; a
  // slice of out-of-range ids and extreme scores is mixed in.
  task automatic add_random(input int n);
    int r;
    int id;
    int cs;
    int inst;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 8) begin
        id = $urandom_range(255, CLASS_COUNT_DEF);
      end else if (r < 45) begin
        id = $urandom_range(7, 0);
      end else begin
        id = $urandom_range(CLASS_COUNT_DEF - 1, 0);
      end
      r  = $urandom_range(99);
      cs = (r < 10) ? 16'hFFFF : (r < 15) ? 0 : $urandom_range(16'hFFFF, 0);
      r  = $urandom_range(99);
      inst = (r < 5) ? 0 : (r < 10) ? 16'hFFFF : $urandom_range(16'hFFFF, 0);
      add_obs(id, cs, inst);
    end
  endtask

  // Holds off new requests until every queued one is taken and every vote
  // has come back, so the block is fully idle.
  task automatic wait_drained();
    while (taken_cnt != queued_cnt || expected_votes.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic report_field(input string field, input int want, input int got);
    if (want != got) begin
      if (err_cnt < 10) begin
        $display("vote %0d: %s expected %0d, got %0d", got_cnt, field, want, got);
      end
      err_cnt++;
    end
  endtask

  // Driver. The model runs at the edge where a request is taken, so the
  // expected vote always exists before the block can answer.
  always @(posedge clk) begin
    if (rst) begin
      obs_valid <= 1'b0;
    end else begin
      if (obs_valid && obs_ready) begin
        expected_votes.push_back(vote_for(obs));
        taken_cnt++;
      end
      // A request still waiting for ready keeps valid and payload as they are.
      if (!obs_valid || obs_ready) begin
        if (pending_obs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          obs       <= pending_obs.pop_front();
          obs_valid <= 1'b1;
        end else begin
          obs_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor. Checks each vote against the oldest expectation and drives
  // vote_ready, including one long stall that backs the block up into its
  // input while the driver keeps offering requests.
  always @(posedge clk) begin : monitor
    vote_t want;
    if (rst) begin
      vote_ready <= 1'b0;
    end else begin
      if (vote_valid && vote_ready) begin
        if (expected_votes.size() == 0) begin
          if (err_cnt < 10) begin
            $display("vote %0d: arrived with no request outstanding", got_cnt);
          end
          err_cnt++;
        end else begin
          want = expected_votes.pop_front();
          report_field("best_class", int'(want.best_class), int'(vote.best_class));
          report_field("best_prob",  int'(want.best_prob),  int'(vote.best_prob));
          report_field("best_valid", int'(want.best_valid), int'(vote.best_valid));
          report_field("status",     int'(want.status),     int'(vote.status));
        end
        got_cnt++;
      end
      if (hold_left > 0) begin
        vote_ready <= 1'b0;
        hold_left  <= hold_left - 1;
      end else if (!hold_done && got_cnt >= HOLD_AT) begin
        vote_ready <= 1'b0;
        hold_left  <= HOLD_LEN;
        hold_done  <= 1'b1;
      end else begin
        vote_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Stimulus sequence: directed corner cases, then three random phases with
  // different idle patterns, then a closing burst of full-scale scores and a bad id.
  // The bench waits for the block to drain between phases.
  initial begin
    @(negedge clk);
    // Out-of-range ids before any class is known: all held fields are zero.
    add_obs(255, 16'hFFFF, 16'hFFFF);
    add_obs(64,  16'h5555, 16'hAAAA);
    add_obs(128, 16'hAAAA, 16'h5555);
    // First sighting with full-scale scores only loads the sums.
    add_obs(0, 16'hFFFF, 16'hFFFF);
    // A class whose weights are all zero never gets a mean.
    add_obs(1, 0, 0);
    add_obs(1, 16'hFFFF, 0);
    // Zero class score gives a zero mean, which cannot beat the reset value.
    add_obs(2, 0, 16'hFFFF);
    add_obs(2, 0, 16'hFFFF);
    // Class 10 takes the lead at one half.
    add_obs(10, 16'h8000, 16'h0100);
    add_obs(10, 16'h8000, 16'h0100);
    // Class 11 ties it and must not take over, then pulls ahead.
    add_obs(11, 16'h8000, 16'h0100);
    add_obs(11, 16'h8000, 16'h0100);
    add_obs(11, 16'hC000, 16'h0100);
    // Alternating bit patterns on both scores and the id.
    add_obs(63, 16'h5555, 16'hAAAA);
    add_obs(63, 16'hAAAA, 16'h5555);
    add_obs(42, 16'hFFFF, 16'h0001);
    add_obs(21, 16'h0001, 16'hFFFF);
    add_obs(42, 16'hFFFF, 16'h0001);
    add_obs(21, 16'h0001, 16'hFFFF);
    // Out-of-range id once a best exists: the held values are shown.
    add_obs(100, 0, 0);
    wait_drained();

    @(negedge clk);
    add_random(150);
    wait_drained();

    @(negedge clk);
    send_idle_pct  = 49;
    recv_stall_pct = 16;
    add_random(150);
    wait_drained();

    // No idling on either side; the long receiver stall happens in here.
    @(negedge clk);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    add_random(150);
    wait_drained();

    // Full-scale repeats on two classes pull their means upward, and a bad
    // id then reports the held result.
    @(negedge clk);
    add_obs(0, 16'hFFFF, 16'hFFFF);
    add_obs(0, 16'hFFFF, 16'hFFFF);
    add_obs(5, 16'hFFFF, 16'hFFFF);
    add_obs(5, 16'hFFFF, 16'hFFFF);
    add_obs(200, 16'h1234, 16'h4321);
    wait_drained();

    // Anything arriving during this quiet stretch is flagged by the monitor.
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("Checked %0d votes from %0d requests: %0d bad ids, %0d first sightings,",
             got_cnt, taken_cnt, n_bad_id, n_first);
    $display("%0d zero-weight updates, %0d lead changes; %0d mismatches.",
             n_zero_w, n_lead, err_cnt);
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #400000;
    $display("simulation failed");
    $finish;
  end

endmodule

[sim.f]
hdl/wcvt_pkg.sv
hdl/wcvt_ram.sv
hdl/wcvt_div.sv
hdl/weighted_class_vote_tracker_top.sv
hdl/wcvt_checker.sv
verif/weighted_class_vote_tracker_top_tb.sv
